[hdl/apdu_dfr_pkg.sv]
// shared constants, phase and status codes and the result type for the report deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apdu_dfr_pkg;

    localparam int MAX_REPORT_SIZE = 64;
    localparam int MIN_REPORT_SIZE = 8;

    // position counter width covers 0 .. MAX_REPORT_SIZE; it counts 0 .. MAX_REPORT_SIZE - 1
    localparam int POS_W  = $clog2(MAX_REPORT_SIZE + 1);
    // width wide enough for both the report_size register and the position
    localparam int SIZE_W = (POS_W > 7) ? POS_W : 7;

    localparam logic [7:0]  REPORT_TAG        = 8'h05;
    localparam logic [15:0] CHANNEL_ID_RESET  = 16'h0101;
    localparam logic [6:0]  REPORT_SIZE_RESET = 7'd64;

    localparam logic CFG_CHANNEL_ID  = 1'b0;
    localparam logic CFG_REPORT_SIZE = 1'b1;

    localparam logic [2:0] PH_CH_HI  = 3'd0;
    localparam logic [2:0] PH_CH_LO  = 3'd1;
    localparam logic [2:0] PH_TAG    = 3'd2;
    localparam logic [2:0] PH_SEQ_HI = 3'd3;
    localparam logic [2:0] PH_SEQ_LO = 3'd4;
    localparam logic [2:0] PH_LEN_HI = 3'd5;
    localparam logic [2:0] PH_LEN_LO = 3'd6;
    localparam logic [2:0] PH_DATA   = 3'd7;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_CHANNEL  = 2'd1;
    localparam logic [1:0] ST_BAD_TAG      = 2'd2;
    localparam logic [1:0] ST_BAD_SEQUENCE = 2'd3;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [1:0]  status;
        logic [15:0] message_length;
    } result_t;

endpackage

`default_nettype wire

[hdl/apdu_dfr_core.sv]
// per-byte header parser and payload counter of the report deframer
// depends on apdu_dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module apdu_dfr_core (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_we,
    input  wire                        cfg_index,
    input  wire [15:0]                 cfg_data,
    input  wire                        step,
    input  wire [7:0]                  in_byte,
    output logic                       res_valid,
    output apdu_dfr_pkg::result_t      res
);

    localparam int POS_W  = apdu_dfr_pkg::POS_W;
    localparam int SIZE_W = apdu_dfr_pkg::SIZE_W;

    logic [15:0]      channel_id_reg;
    logic [6:0]       report_size_reg;

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       held_reg, held_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      total_reg, total_next;
    logic [15:0]      rem_reg, rem_next;

    logic [15:0]       word;
    logic [SIZE_W-1:0] size_ext;
    logic [SIZE_W-1:0] used_size;
    logic [SIZE_W-1:0] pos_inc;

    assign word     = {held_reg, in_byte};
    assign size_ext = SIZE_W'(report_size_reg);

    always_comb begin
        if (size_ext < SIZE_W'(apdu_dfr_pkg::MIN_REPORT_SIZE)) begin
            used_size = SIZE_W'(apdu_dfr_pkg::MIN_REPORT_SIZE);
        end else if (size_ext > SIZE_W'(apdu_dfr_pkg::MAX_REPORT_SIZE)) begin
            used_size = SIZE_W'(apdu_dfr_pkg::MAX_REPORT_SIZE);
        end else begin
            used_size = size_ext;
        end
    end

    assign pos_inc = SIZE_W'(pos_reg) + SIZE_W'(1);

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        seq_next   = seq_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res        = '{payload_byte: 8'd0, last_byte: 1'b1,
                       status: apdu_dfr_pkg::ST_OK, message_length: 16'd0};

        unique case (phase_reg)
            apdu_dfr_pkg::PH_CH_HI: begin
                held_next  = in_byte;
                phase_next = apdu_dfr_pkg::PH_CH_LO;
            end
            apdu_dfr_pkg::PH_CH_LO: begin
                if (word != channel_id_reg) begin
                    res_valid  = 1'b1;
                    res.status = apdu_dfr_pkg::ST_BAD_CHANNEL;
                    phase_next = apdu_dfr_pkg::PH_DATA;
                    rem_next   = 16'd0;
                end else begin
                    phase_next = apdu_dfr_pkg::PH_TAG;
                end
            end
            apdu_dfr_pkg::PH_TAG: begin
                if (in_byte != apdu_dfr_pkg::REPORT_TAG) begin
                    res_valid  = 1'b1;
                    res.status = apdu_dfr_pkg::ST_BAD_TAG;
                    phase_next = apdu_dfr_pkg::PH_DATA;
                    rem_next   = 16'd0;
                end else begin
                    phase_next = apdu_dfr_pkg::PH_SEQ_HI;
                end
            end
            apdu_dfr_pkg::PH_SEQ_HI: begin
                held_next  = in_byte;
                phase_next = apdu_dfr_pkg::PH_SEQ_LO;
            end
            apdu_dfr_pkg::PH_SEQ_LO: begin
                if (word != seq_reg) begin
                    res_valid  = 1'b1;
                    res.status = apdu_dfr_pkg::ST_BAD_SEQUENCE;
                    phase_next = apdu_dfr_pkg::PH_DATA;
                    rem_next   = 16'd0;
                end else begin
                    seq_next   = seq_reg + 16'd1;
                    // first report of a message carries the length field
                    phase_next = (rem_reg == 16'd0) ? apdu_dfr_pkg::PH_LEN_HI
                                                    : apdu_dfr_pkg::PH_DATA;
                end
            end
            apdu_dfr_pkg::PH_LEN_HI: begin
                held_next  = in_byte;
                phase_next = apdu_dfr_pkg::PH_LEN_LO;
            end
            apdu_dfr_pkg::PH_LEN_LO: begin
                total_next = word;
                rem_next   = word;
                phase_next = apdu_dfr_pkg::PH_DATA;
            end
            apdu_dfr_pkg::PH_DATA: begin
                if (rem_reg != 16'd0) begin
                    rem_next  = rem_reg - 16'd1;
                    res_valid = 1'b1;
                    res       = '{payload_byte: in_byte,
                                  last_byte: (rem_reg == 16'd1),
                                  status: apdu_dfr_pkg::ST_OK,
                                  message_length: total_reg};
                end
            end
        endcase

        // end of report: drop an unfinished header or a finished message
        if (pos_inc >= used_size) begin
            pos_next = '0;
            if (phase_next != apdu_dfr_pkg::PH_DATA || rem_next == 16'd0) begin
                seq_next = 16'd0;
                rem_next = 16'd0;
            end
            phase_next = apdu_dfr_pkg::PH_CH_HI;
        end else begin
            pos_next = pos_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_id_reg  <= apdu_dfr_pkg::CHANNEL_ID_RESET;
            report_size_reg <= apdu_dfr_pkg::REPORT_SIZE_RESET;
        end else if (cfg_we) begin
            if (cfg_index == apdu_dfr_pkg::CFG_CHANNEL_ID) begin
                channel_id_reg <= cfg_data;
            end else begin
                report_size_reg <= cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= apdu_dfr_pkg::PH_CH_HI;
            pos_reg   <= '0;
            held_reg  <= 8'd0;
            seq_reg   <= 16'd0;
            total_reg <= 16'd0;
            rem_reg   <= 16'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            seq_reg   <= seq_next;
            total_reg <= total_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

[hdl/apdu_report_deframer_top.sv]
// top level of the report deframer: parser core plus a two-entry result queue
// depends on apdu_dfr_pkg and apdu_dfr_core
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   input channel s_valid / s_ready / s_in_byte: one raw report byte per request
//   result channel m_valid / m_ready / m_payload_byte, m_last_byte, m_status,
//   m_message_length: zero or one result per input byte, in input order
//   config port cfg_we / cfg_index / cfg_data: index 0 channel word, index 1
//   report size (clamped to 8..MAX_REPORT_SIZE); write only while idle
// Timing
//   one input byte is taken every cycle while s_ready is high; the header
//   compare and counters run in the cycle of acceptance and the result lands
//   in a queue register before it shows on the m_ side
//   throughput is one byte per cycle, limited only by the result queue
// Stall
//   the two-entry result queue lets the block take a byte while a result
//   waits; s_ready drops only when both entries hold results
// Reset
//   aresetn is synchronous active low; it empties the queue, restores the
//   register defaults and starts at the channel word of a fresh report
module apdu_report_deframer_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_in_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_byte,
    output logic [1:0]  m_status,
    output logic [15:0] m_message_length
);

    logic                  accept;
    logic                  res_valid;
    apdu_dfr_pkg::result_t res;

    // result queue
    apdu_dfr_pkg::result_t slot_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            count_reg, count_next;
    logic                  push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign accept  = s_valid & s_ready;

    apdu_dfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .in_byte   (s_in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    assign push = accept & res_valid;
    assign pop  = m_valid & m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // payload slots carry no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign m_valid          = (count_reg != 2'd0);
    assign m_payload_byte   = slot_reg[rd_ptr_reg].payload_byte;
    assign m_last_byte      = slot_reg[rd_ptr_reg].last_byte;
    assign m_status         = slot_reg[rd_ptr_reg].status;
    assign m_message_length = slot_reg[rd_ptr_reg].message_length;

    // queue never holds more than two results
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("result queue overflow");

    // an error result is always a zeroed, last-marked item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != apdu_dfr_pkg::ST_OK) |->
        (m_last_byte && m_payload_byte == 8'd0 && m_message_length == 16'd0))
        else $error("malformed error result");

    // input stalls only while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("input stalled with empty queue");

    // after a push the queue holds a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn) push |=> m_valid)
        else $error("pushed result not visible");

    // reset empties the queue
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("queue not empty after reset");

endmodule

`default_nettype wire
